// ===== rtl/keyboard_scancode_key_map_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Keyboard scan-code key map: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_KEY_MAP_UNIT_MACROS_SVH
`define KEYBOARD_SCANCODE_KEY_MAP_UNIT_MACROS_SVH

// Same-cycle implication.
`define KSKM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KSKM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kskm_pkg.sv =====
// ---------------------------------------------------------------------------
// Keyboard scan-code key map package
// Shared types and constants of the key map block.
// ---------------------------------------------------------------------------
`default_nettype none

package kskm_pkg;

    localparam int MAP_DEPTH = 256;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int HELD_W    = $clog2(MAP_DEPTH) + 1;

    localparam logic [HELD_W-1:0] HELD_MAX = HELD_W'(MAP_DEPTH);

    localparam logic [7:0] SCAN_E0     = 8'hE0;
    localparam logic [7:0] SCAN_E1     = 8'hE1;
    localparam logic [7:0] SCAN_PAUSE  = 8'h45;
    localparam logic [7:0] PAUSE_ENTRY = 8'hC5;

    typedef enum logic [1:0] {
        PFX_IDLE = 2'd0,
        PFX_E0   = 2'd1,
        PFX_E1   = 2'd2,
        PFX_E1B  = 2'd3
    } prefix_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_SET  = 2'd1,
        OP_CLR  = 2'd2,
        OP_TOG  = 2'd3
    } key_op_t;

    // Decoded action for one scan byte.
    typedef struct packed {
        logic [MAP_AW-1:0] idx;
        logic              touched;
        key_op_t           op;
        prefix_t           prefix_next;
    } dec_t;

endpackage

`default_nettype wire

// ===== rtl/kskm_if.sv =====
// ---------------------------------------------------------------------------
// Keyboard scan-code key map channels
// Valid/ready channels for scan bytes in and key map results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface kskm_scan_if;
    import kskm_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface kskm_key_if;
    import kskm_pkg::*;

    logic              valid;
    logic              ready;
    logic [MAP_AW-1:0] key_index;
    logic              key_changed;
    logic              key_down;
    logic [HELD_W-1:0] held_count;
    logic [1:0]        prefix_now;

    modport source (output valid, output key_index, output key_changed,
                    output key_down, output held_count, output prefix_now,
                    input ready);
    modport sink   (input valid, input key_index, input key_changed,
                    input key_down, input held_count, input prefix_now,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/kskm_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with read enable and registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module kskm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kskm_dec.sv =====
// ---------------------------------------------------------------------------
// Keyboard scan-code prefix decoder
// Next prefix state and map action for one scan byte.
// ---------------------------------------------------------------------------
`default_nettype none

module kskm_dec (
    input  wire logic [7:0]       scan_byte,
    input  wire kskm_pkg::prefix_t prefix,
    output      kskm_pkg::dec_t    dec
);
    import kskm_pkg::*;

    prefix_t           prefix_next;
    logic [MAP_AW-1:0] map_idx;
    logic              touched;
    key_op_t           op;

    // Next state
    always_comb
    begin
        prefix_next = PFX_IDLE;
        unique case (prefix)
            PFX_IDLE:
            begin
                if (scan_byte == SCAN_E0)
                begin
                    prefix_next = PFX_E0;
                end
                else if (scan_byte == SCAN_E1)
                begin
                    prefix_next = PFX_E1;
                end
            end
            PFX_E0:  prefix_next = PFX_IDLE;
            PFX_E1:  prefix_next = PFX_E1B;
            PFX_E1B: prefix_next = PFX_IDLE;
            default: prefix_next = PFX_IDLE;
        endcase
    end

    // Map action: bit seven marks a break
    always_comb
    begin
        map_idx = '0;
        touched = 1'b0;
        op      = OP_NONE;
        unique case (prefix)
            PFX_IDLE:
            begin
                if (scan_byte != SCAN_E0 && scan_byte != SCAN_E1)
                begin
                    map_idx = {1'b0, scan_byte[6:0]};
                    touched = 1'b1;
                    op      = scan_byte[7] ? OP_CLR : OP_SET;
                end
            end
            PFX_E0:
            begin
                map_idx = {1'b1, scan_byte[6:0]};
                touched = 1'b1;
                op      = scan_byte[7] ? OP_CLR : OP_SET;
            end
            PFX_E1:
            begin
                touched = 1'b0;
            end
            PFX_E1B:
            begin
                if (scan_byte == SCAN_PAUSE)
                begin
                    map_idx = PAUSE_ENTRY;
                    touched = 1'b1;
                    op      = OP_TOG;
                end
            end
            default:
            begin
                touched = 1'b0;
            end
        endcase
    end

    assign dec = '{idx: map_idx, touched: touched, op: op, prefix_next: prefix_next};

endmodule

`default_nettype wire

// ===== rtl/keyboard_scancode_key_map_unit.sv =====
// ---------------------------------------------------------------------------
// Keyboard scan-code set 1 key map unit
// Tracks pressed keys from raw set-1 scan bytes in a 256-entry map.
// ---------------------------------------------------------------------------
// Usage:
//   scan  (sink)   one raw scan byte per item.
//   key   (source) exactly one result item per scan byte, in order: the map
//                  entry touched, whether it flipped, its new value, the held
//                  key count and the prefix state after the byte.
//   Pipeline: an accepted byte is decoded and its map entry read into the read
//   stage, then read-modify-written into the output register.
//   Throughput: one byte per cycle while key.ready is high; the map RAM does
//   one read and one write each cycle, and the write of the previous byte is
//   forwarded into the read-modify-write of the next one on the same entry.
//   Reset: the held count, prefix state and per-entry valid bits clear at once;
//   the valid bits make unwritten map entries read as released, so
//   no clearing pass is needed and bytes are taken straight after reset.
//   Stall: when key.ready is low the result holds, the byte in the RAM read
//   stage holds behind it, and scan.ready drops until the output drains.
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyboard_scancode_key_map_unit_macros.svh"

module keyboard_scancode_key_map_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    kskm_scan_if.sink  scan,
    kskm_key_if.source key
);
    import kskm_pkg::*;

    // Prefix state, updated as each byte is accepted
    prefix_t prefix_reg;
    dec_t    dec;

    // Read stage: byte waiting on its map read
    logic              s1_valid_reg;
    logic [MAP_AW-1:0] s1_idx_reg;
    logic              s1_touched_reg;
    key_op_t           s1_op_reg;
    prefix_t           s1_prefix_reg;
    logic              s1_vld_bit_reg;

    // Last map write, for forwarding into the next read-modify-write
    logic              fwd_valid_reg;
    logic [MAP_AW-1:0] fwd_idx_reg;
    logic              fwd_data_reg;

    // Per-entry written flags and held key count
    logic [MAP_DEPTH-1:0] mvld_reg;
    logic [MAP_DEPTH-1:0] mvld_next;
    logic [HELD_W-1:0]    held_reg;
    logic [HELD_W-1:0]    held_next;

    // Output register
    logic              out_valid_reg;
    logic [MAP_AW-1:0] out_idx_reg;
    logic              out_changed_reg;
    logic              out_down_reg;
    logic [HELD_W-1:0] out_held_reg;
    prefix_t           out_prefix_reg;

    logic accept;
    logic s1_adv;
    logic ram_q;
    logic old_bit;
    logic new_bit;
    logic changed;
    logic map_we;

    kskm_dec u_dec (
        .scan_byte (scan.scan_byte),
        .prefix    (prefix_reg),
        .dec       (dec)
    );

    // Advance the read stage when the output register is free or draining
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || key.ready);
    assign scan.ready = !s1_valid_reg || s1_adv;
    assign accept     = scan.valid && scan.ready;

    // The map: read on accept, written as the byte leaves the read stage
    kskm_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (s1_idx_reg),
        .wdata (new_bit),
        .re    (accept),
        .raddr (dec.idx),
        .rdata (ram_q)
    );

    // Old value: forwarded write first, else RAM if the entry was ever written
    always_comb
    begin
        if (fwd_valid_reg && fwd_idx_reg == s1_idx_reg)
        begin
            old_bit = fwd_data_reg;
        end
        else
        begin
            old_bit = s1_vld_bit_reg & ram_q;
        end
    end

    always_comb
    begin
        case (s1_op_reg)
            OP_SET:  new_bit = 1'b1;
            OP_CLR:  new_bit = 1'b0;
            OP_TOG:  new_bit = !old_bit;
            default: new_bit = old_bit;
        endcase
    end

    assign changed = s1_touched_reg && (new_bit != old_bit);
    assign map_we  = s1_adv && s1_touched_reg;

    // Count moves only on real flips and stays inside 0..256
    always_comb
    begin
        held_next = held_reg;
        if (changed && new_bit && held_reg < HELD_MAX)
        begin
            held_next = held_reg + HELD_W'(1);
        end
        else if (changed && !new_bit && held_reg != '0)
        begin
            held_next = held_reg - HELD_W'(1);
        end
    end

    always_comb
    begin
        mvld_next = mvld_reg;
        if (map_we)
        begin
            mvld_next[s1_idx_reg] = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= PFX_IDLE;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            mvld_reg      <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prefix_reg <= dec.prefix_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (map_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            mvld_reg <= mvld_next;
            if (s1_adv)
            begin
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (key.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg     <= dec.idx;
            s1_touched_reg <= dec.touched;
            s1_op_reg      <= dec.op;
            s1_prefix_reg  <= dec.prefix_next;
            s1_vld_bit_reg <= mvld_reg[dec.idx];
        end
        if (map_we)
        begin
            fwd_idx_reg  <= s1_idx_reg;
            fwd_data_reg <= new_bit;
        end
        if (s1_adv)
        begin
            out_idx_reg     <= s1_touched_reg ? s1_idx_reg : '0;
            out_changed_reg <= changed;
            out_down_reg    <= s1_touched_reg & new_bit;
            out_held_reg    <= held_next;
            out_prefix_reg  <= s1_prefix_reg;
        end
    end

    assign key.valid       = out_valid_reg;
    assign key.key_index   = out_idx_reg;
    assign key.key_changed = out_changed_reg;
    assign key.key_down    = out_down_reg;
    assign key.held_count  = out_held_reg;
    assign key.prefix_now  = out_prefix_reg;

    `KSKM_ASSERT_IMPL(a_held_range, clk, rst_n, 1'b1, held_reg <= HELD_MAX, "held count above map size")
    `KSKM_ASSERT_IMPL(a_no_accept_on_stall, clk, rst_n, s1_valid_reg && !s1_adv, !accept, "byte accepted while read stage stalled")
    `KSKM_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, s1_adv, out_valid_reg, "result lost on advance")
    `KSKM_ASSERT_IMPL(a_write_marks_entry, clk, rst_n, fwd_valid_reg, mvld_reg[fwd_idx_reg], "forwarded entry not marked written")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Keyboard scan-code key map unit testbench
// Feeds set-1 scan bytes through the valid/ready channel and checks every
// result item against a cycle-free predictor of the key map, held count
// and prefix state, with random idling on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kskm_pkg::*;

    // Set-1 bit layout: bit seven marks a break, the low seven bits the key.
    localparam logic [7:0] EXT_BIT   = 8'h80;
    localparam logic [7:0] CODE_MASK = 8'h7F;

    // Bytes of the pause key sequence around the E1 prefixes.
    localparam logic [7:0] PAUSE_CTRL_MAKE  = 8'h1D;
    localparam logic [7:0] PAUSE_CTRL_BREAK = 8'h9D;
    localparam logic [7:0] PAUSE_BREAK      = 8'hC5;

    localparam int MAX_WAIT      = 8;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [MAP_AW-1:0] key_index;
        logic              key_changed;
        logic              key_down;
        logic [HELD_W-1:0] held_count;
        logic [1:0]        prefix_now;
    } key_result_t;

    typedef struct {
        logic [7:0] code;
        bit         drain;   // hold this byte back until every result is in
    } scan_item_t;

    logic clk = 1'b0;
    logic rst_n;

    kskm_scan_if scan_ch ();
    kskm_key_if  key_ch ();

    keyboard_scancode_key_map_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan_ch.sink),
        .key   (key_ch.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predicted key map state
    // -----------------------------------------------------------------------
    bit          pressed_map [MAP_DEPTH];
    logic [8:0]  held_keys;
    prefix_t     prefix_model;

    scan_item_t  scan_queue[$];
    key_result_t expected_keys[$];

    int unsigned fault_count    = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned queued_total   = 0;

    // Apply one scan byte to the predicted map and return the result item
    // the block should produce for it.
    function automatic key_result_t apply_scan_byte(input logic [7:0] code);
        key_result_t res;
        key_op_t     op;
        logic [7:0]  entry;
        bit          new_val;
        begin
            op    = OP_NONE;
            entry = '0;
            res   = '0;
            case (prefix_model)
                PFX_IDLE:
                begin
                    if (code == SCAN_E0)
                        prefix_model = PFX_E0;
                    else if (code == SCAN_E1)
                        prefix_model = PFX_E1;
                    else
                    begin
                        entry = code & CODE_MASK;
                        op    = (code & EXT_BIT) != 0 ? OP_CLR : OP_SET;
                    end
                end
                PFX_E0:
                begin
                    // Extended keys live in the upper half of the map.
                    entry        = code | EXT_BIT;
                    op           = (code & EXT_BIT) != 0 ? OP_CLR : OP_SET;
                    prefix_model = PFX_IDLE;
                end
                PFX_E1:
                    prefix_model = PFX_E1B;
                default:
                begin
                    if (code == SCAN_PAUSE)
                    begin
                        entry = PAUSE_ENTRY;
                        op    = OP_TOG;
                    end
                    prefix_model = PFX_IDLE;
                end
            endcase

            if (op != OP_NONE)
            begin
                case (op)
                    OP_SET:  new_val = 1'b1;
                    OP_CLR:  new_val = 1'b0;
                    default: new_val = !pressed_map[entry];
                endcase
                if (new_val != pressed_map[entry])
                begin
                    pressed_map[entry] = new_val;
                    res.key_changed    = 1'b1;
                    if (new_val && held_keys < HELD_MAX)
                        held_keys = held_keys + 1'b1;
                    else if (!new_val && held_keys != 0)
                        held_keys = held_keys - 1'b1;
                end
                res.key_index = entry;
                res.key_down  = pressed_map[entry];
            end
            res.held_count = held_keys;
            res.prefix_now = prefix_model;
            return res;
        end
    endfunction

    // Quiet stretches with no idling come and go with the item count.
    function automatic int unsigned draw_wait(input bit calm);
        begin
            return calm ? 0 : $urandom_range(0, MAX_WAIT);
        end
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
                $display("ERROR at %0t: %s expected 0x%0h, got 0x%0h",
                         $realtime, what, want, got);
        end
    endtask

    task automatic queue_byte(input logic [7:0] code, input bit drain = 1'b0);
        scan_item_t item;
        begin
            item.code  = code;
            item.drain = drain;
            scan_queue.push_back(item);
            queued_total++;
        end
    endtask

    // Queue one well-formed key sequence with random content, or some noise.
    task automatic add_random_sequence();
        logic [6:0]  k;
        int unsigned pick;
        begin
            // Half the keys come from a narrow window so repeats and
            // re-presses of the same entry are common.
            k    = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 15))
                                               : 7'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 30)
                queue_byte({1'b0, k});
            else if (pick < 55)
                queue_byte({1'b1, k});
            else if (pick < 70)
            begin
                queue_byte(SCAN_E0);
                queue_byte({1'b0, k});
            end
            else if (pick < 82)
            begin
                queue_byte(SCAN_E0);
                queue_byte({1'b1, k});
            end
            else if (pick < 87)
            begin
                queue_byte(SCAN_E1);
                queue_byte(PAUSE_CTRL_MAKE);
                queue_byte(SCAN_PAUSE);
                queue_byte(SCAN_E1);
                queue_byte(PAUSE_CTRL_BREAK);
                queue_byte(PAUSE_BREAK);
            end
            else if (pick < 95)
                queue_byte(8'($urandom_range(0, 255)));
            else
            begin
                // Broken E1 sequence: random bytes where the pause codes go.
                queue_byte(SCAN_E1);
                queue_byte(8'($urandom_range(0, 255)));
                queue_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Driver: present queued scan bytes, predict each one as it is taken
    // -----------------------------------------------------------------------
    logic [3:0] send_gap;

    always @(posedge clk or negedge rst_n)
    begin
        bit took;
        if (!rst_n)
        begin
            scan_ch.valid     <= 1'b0;
            scan_ch.scan_byte <= '0;
            send_gap          <= '0;
        end
        else
        begin
            took = scan_ch.valid && scan_ch.ready;
            if (took)
            begin
                expected_keys.push_back(apply_scan_byte(scan_ch.scan_byte));
                items_accepted++;
            end

            if (scan_ch.valid && !took)
            begin
                // hold the item until the block takes it
            end
            else if (send_gap != 0)
            begin
                send_gap      <= send_gap - 1'b1;
                scan_ch.valid <= 1'b0;
            end
            else if (scan_queue.size() != 0 &&
                     (!scan_queue[0].drain || expected_keys.size() == 0))
            begin
                scan_ch.valid     <= 1'b1;
                scan_ch.scan_byte <= scan_queue[0].code;
                send_gap          <= 4'(draw_wait(((items_accepted / 90) % 3) == 0));
                void'(scan_queue.pop_front());
            end
            else
                scan_ch.valid <= 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: take result items with random stalls, check each field
    // -----------------------------------------------------------------------
    logic [3:0] hold_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        key_result_t want;
        int unsigned stall;
        if (!rst_n)
        begin
            key_ch.ready <= 1'b0;
            hold_cnt     <= '0;
        end
        else if (key_ch.valid && key_ch.ready)
        begin
            results_seen++;
            if (expected_keys.size() == 0)
                note_mismatch("unexpected item, key_index", 0, key_ch.key_index);
            else
            begin
                want = expected_keys.pop_front();
                if (key_ch.key_index !== want.key_index)
                    note_mismatch("key_index", want.key_index, key_ch.key_index);
                if (key_ch.key_changed !== want.key_changed)
                    note_mismatch("key_changed", want.key_changed, key_ch.key_changed);
                if (key_ch.key_down !== want.key_down)
                    note_mismatch("key_down", want.key_down, key_ch.key_down);
                if (key_ch.held_count !== want.held_count)
                    note_mismatch("held_count", want.held_count, key_ch.held_count);
                if (key_ch.prefix_now !== want.prefix_now)
                    note_mismatch("prefix_now", want.prefix_now, key_ch.prefix_now);
            end
            stall        = draw_wait(((results_seen / 70) % 4) == 1);
            hold_cnt     <= 4'(stall);
            key_ch.ready <= (stall == 0);
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt     <= hold_cnt - 1'b1;
            key_ch.ready <= (hold_cnt == 1);
        end
        else
            key_ch.ready <= 1'b1;
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run
    // -----------------------------------------------------------------------
    initial
    begin
        int unsigned k;
        logic [7:0]  code;

        rst_n = 1'b0;

        for (k = 0; k < MAP_DEPTH; k++)
            pressed_map[k] = 1'b0;
        held_keys    = '0;
        prefix_model = PFX_IDLE;

        // Plain make and break at both ends of the code range, a break of a
        // released key and a repeated make.
        queue_byte(8'h00);
        queue_byte(8'h7F);
        queue_byte(8'hFF);
        queue_byte(8'h80);
        queue_byte(8'h80);
        queue_byte(8'h01);
        queue_byte(8'h01);
        // Extended make and break, a break of a released extended key, and
        // E0 following E0, which acts as an extended break.
        queue_byte(SCAN_E0);
        queue_byte(8'h1D);
        queue_byte(SCAN_E0);
        queue_byte(8'h9D);
        queue_byte(SCAN_E0);
        queue_byte(8'hAA);
        queue_byte(SCAN_E0);
        queue_byte(SCAN_E0);
        queue_byte(SCAN_E0);
        queue_byte(8'h7F);
        queue_byte(SCAN_E0);
        queue_byte(8'hFF);
        // Pause press, its break sequence, then pause again to toggle off.
        queue_byte(SCAN_E1);
        queue_byte(PAUSE_CTRL_MAKE);
        queue_byte(SCAN_PAUSE);
        queue_byte(SCAN_E1);
        queue_byte(PAUSE_CTRL_BREAK);
        queue_byte(PAUSE_BREAK);
        queue_byte(SCAN_E1);
        queue_byte(PAUSE_CTRL_MAKE);
        queue_byte(SCAN_PAUSE, 1'b1);

        repeat (150)
            add_random_sequence();

        // Press every entry so the count reaches its top, re-press one key
        // at the top, then release all that can be released.
        queue_byte(8'h00, 1'b1);
        for (k = 1; k < 128; k++)
            queue_byte(8'(k));
        for (k = 0; k < 128; k++)
        begin
            queue_byte(SCAN_E0);
            queue_byte(8'(k));
        end
        queue_byte(8'h10);
        for (k = 0; k < 128; k++)
        begin
            code = 8'(k) | EXT_BIT;
            if (code != SCAN_E0 && code != SCAN_E1)
                queue_byte(code);
        end
        for (k = 128; k < 256; k++)
        begin
            queue_byte(SCAN_E0);
            queue_byte(8'(k));
        end

        while (queued_total < RANDOM_ITEMS)
            add_random_sequence();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every byte to go in and every result to come back.
        while (scan_queue.size() != 0 || scan_ch.valid || expected_keys.size() != 0)
            @(posedge clk);
        // Allow for the two-stage pipeline, catching any stray result.
        repeat (10) @(posedge clk);

        if (expected_keys.size() != 0)
            note_mismatch("items left without result", 0, expected_keys.size());

        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #400_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
